// ===== hw/rtl/eucd_pkg.sv =====
// Shared types and constants of the Euclidean distance block.
package eucd_pkg;

  localparam int ACC_W       = 54;         // accumulator width
  localparam int DIST_W      = 27;         // distance width, Q19.8
  localparam int SQRT_STAGES = ACC_W / 2;  // one root bit per cell
  localparam int OUT_TDATA_W = ((DIST_W + 7) / 8) * 8;

  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

  // Word handed along the square-root chain.
  typedef struct packed {
    logic [ACC_W-1:0] rem;   // remaining radicand
    logic [ACC_W-1:0] root;  // partial root, shifted form
    logic             sat;   // accumulator saturated in this pair
  } sqrt_word_t;

endpackage

// ===== hw/rtl/eucd_mac.sv =====
// Front end: absolute difference, square, saturating accumulate, hand-off register.
module eucd_mac #(
  parameter int COORD_BITS = 24
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_valid_i,
  output logic                    s_ready_o,
  input  logic [COORD_BITS-1:0]   coord_a_i,
  input  logic [COORD_BITS-1:0]   coord_b_i,
  input  logic                    last_i,
  output logic                    h_valid_o,
  input  logic                    h_ready_i,
  output eucd_pkg::sqrt_word_t    h_word_o
);

  localparam int SQ_W  = 2 * COORD_BITS;
  localparam int SUM_W = ((SQ_W > eucd_pkg::ACC_W) ? SQ_W : eucd_pkg::ACC_W) + 1;

  // stage A: difference
  logic                  va_q;
  logic                  lasta_q;
  logic [COORD_BITS-1:0] diff_q, diff_d;
  // stage B: square
  logic                  vb_q;
  logic                  lastb_q;
  logic [SQ_W-1:0]       sq_q, sq_d;
  // accumulator
  logic [eucd_pkg::ACC_W-1:0] acc_q, acc_d;
  logic                       ovf_q, ovf_d;
  logic [SUM_W-1:0]           sum;
  logic                       ovf_add;
  // hand-off
  logic                 hv_q;
  eucd_pkg::sqrt_word_t hw_q;

  logic ready_a, ready_b, leave_b, free_h;

  assign diff_d = (coord_a_i >= coord_b_i) ? (coord_a_i - coord_b_i)
                                           : (coord_b_i - coord_a_i);
  assign sq_d   = SQ_W'(diff_q) * SQ_W'(diff_q);

  assign sum     = SUM_W'(acc_q) + SUM_W'(sq_q);
  assign ovf_add = |sum[SUM_W-1:eucd_pkg::ACC_W];
  assign acc_d   = ovf_add ? eucd_pkg::ACC_MAX : sum[eucd_pkg::ACC_W-1:0];
  assign ovf_d   = ovf_q | ovf_add;

  assign free_h  = !hv_q || h_ready_i;
  assign leave_b = vb_q && (!lastb_q || free_h);
  assign ready_b = !vb_q || leave_b;
  assign ready_a = !va_q || ready_b;

  assign s_ready_o = ready_a;
  assign h_valid_o = hv_q;
  assign h_word_o  = hw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q  <= 1'b0;
      vb_q  <= 1'b0;
      hv_q  <= 1'b0;
      acc_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      if (ready_a) begin
        va_q <= s_valid_i;
      end
      if (ready_b) begin
        vb_q <= va_q;
      end
      if (leave_b) begin
        if (lastb_q) begin
          acc_q <= '0;
          ovf_q <= 1'b0;
        end else begin
          acc_q <= acc_d;
          ovf_q <= ovf_d;
        end
      end
      if (free_h) begin
        hv_q <= leave_b && lastb_q;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (ready_a && s_valid_i) begin
      diff_q  <= diff_d;
      lasta_q <= last_i;
    end
    if (ready_b && va_q) begin
      sq_q    <= sq_d;
      lastb_q <= lasta_q;
    end
    if (free_h && leave_b && lastb_q) begin
      hw_q.rem  <= acc_d;
      hw_q.root <= '0;
      hw_q.sat  <= ovf_d;
    end
  end

endmodule

// ===== hw/rtl/eucd_sqrt_cell.sv =====
// One cell of the square-root chain: settles one root bit per pass.
module eucd_sqrt_cell #(
  parameter int STAGE = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  eucd_pkg::sqrt_word_t in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output eucd_pkg::sqrt_word_t out_word_o
);

  localparam int               SHIFT   = eucd_pkg::ACC_W - 2 - 2 * STAGE;
  localparam logic [eucd_pkg::ACC_W-1:0] TRY_BIT =
    {{(eucd_pkg::ACC_W-1){1'b0}}, 1'b1} << SHIFT;

  logic                       valid_q;
  eucd_pkg::sqrt_word_t       word_q, word_d;
  logic [eucd_pkg::ACC_W-1:0] trial;
  logic                       fits;

  assign trial = in_word_i.root + TRY_BIT;
  assign fits  = in_word_i.rem >= trial;

  always_comb begin
    word_d.sat = in_word_i.sat;
    if (fits) begin
      word_d.rem  = in_word_i.rem - trial;
      word_d.root = (in_word_i.root >> 1) + TRY_BIT;
    end else begin
      word_d.rem  = in_word_i.rem;
      word_d.root = in_word_i.root >> 1;
    end
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      word_q <= word_d;
    end
  end

endmodule

// ===== hw/rtl/euclidean_distance_nd_top.sv =====
// Top level of the streaming N-dimensional Euclidean distance block.
// Each input transaction carries one dimension of a point pair: coordinate a
// in the low COORD_BITS of s_axis_tdata, coordinate b above it, and tlast on
// the final dimension. Coordinates are unsigned Q16.8. While the master side
// does not stall, one transaction is taken per clock cycle, sustained, with
// no gap between point pairs: the difference, the square and the saturating
// 54-bit accumulate form a registered front end that absorbs one dimension
// per cycle, and the floor square root runs down a chain of 27 cells, one
// root bit per cell, so several pairs can be in the chain at once. The
// transaction carrying tlast passes the difference register, the square
// register, the hand-off register and the 27 chain cells in that order
// before its result appears on the master side; a stall on the master side
// delays it further. tdata of the result holds the Q19.8 distance; tuser is
// set when the accumulator saturated during that pair, in which case the
// distance reads all ones. Pairs longer than any dimension limit simply
// keep accumulating.
module euclidean_distance_nd_top #(
  parameter int COORD_BITS = 24
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // slave side; tdata fields from bit 0: coord_a, coord_b, zero fill
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [((2*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  input  logic                            s_axis_tlast,   // last_dim
  // master side; tdata fields from bit 0: distance, zero fill
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [eucd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                            m_axis_tuser    // saturated
);

  localparam int N = eucd_pkg::SQRT_STAGES;

  // chain links: index k feeds cell k, index N is the chain output
  logic                 link_valid [N+1];
  logic                 link_ready [N+1];
  eucd_pkg::sqrt_word_t link_word  [N+1];

  // front end: diff, square, accumulate, hand-off into the chain
  eucd_mac #(
    .COORD_BITS (COORD_BITS)
  ) u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .coord_a_i (s_axis_tdata[COORD_BITS-1:0]),
    .coord_b_i (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
    .last_i    (s_axis_tlast),
    .h_valid_o (link_valid[0]),
    .h_ready_i (link_ready[0]),
    .h_word_o  (link_word[0])
  );

  // square-root chain; cell k tries bit 2^(52-2k)
  for (genvar k = 0; k < N; k++) begin : g_cell
    eucd_sqrt_cell #(
      .STAGE (k)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (link_valid[k]),
      .in_ready_o  (link_ready[k]),
      .in_word_i   (link_word[k]),
      .out_valid_o (link_valid[k+1]),
      .out_ready_i (link_ready[k+1]),
      .out_word_o  (link_word[k+1])
    );
  end

  // last cell's register is the output register
  assign link_ready[N] = m_axis_tready;
  assign m_axis_tvalid = link_valid[N];
  assign m_axis_tdata  = eucd_pkg::OUT_TDATA_W'(link_word[N].root[eucd_pkg::DIST_W-1:0]);
  assign m_axis_tuser  = link_word[N].sat;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------

  // finished root fits the distance field
  a_root_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (link_word[N].root[eucd_pkg::ACC_W-1:eucd_pkg::DIST_W] == '0))
    else $error("square root exceeds distance width");

  // floor root: remainder never above twice the root
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (link_word[N].rem <= {link_word[N].root[eucd_pkg::ACC_W-2:0], 1'b0}))
    else $error("square root remainder out of range");

  // a saturated sum gives the largest distance
  a_sat_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |->
      (m_axis_tdata[eucd_pkg::DIST_W-1:0] == {eucd_pkg::DIST_W{1'b1}}))
    else $error("saturated pair without full-scale distance");

  // input only stalls when a result is backed up at the output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output backpressure");

endmodule
